/* rtl/sntp_client_time_keeper_assert.svh */
// ----------------------------------------------------------------------------
// SNTP time keeper assertion macros
// Shared concurrent assertion forms for the time keeper modules.
// ----------------------------------------------------------------------------
`ifndef SNTP_CLIENT_TIME_KEEPER_ASSERT_SVH
`define SNTP_CLIENT_TIME_KEEPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define STK_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sntp_tk_pkg.sv */
// ----------------------------------------------------------------------------
// SNTP time keeper package
// Types, register codes and constants shared by the time keeper modules.
// ----------------------------------------------------------------------------
package sntp_tk_pkg;

  // Seconds from 1900-01-01 to 1970-01-01.
  localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;

  // floor(x / 1000) == (x * MS_DIV_MAGIC) >> MS_DIV_SHIFT for every 32-bit x.
  localparam logic [31:0] MS_DIV_MAGIC = 32'h10624DD3;
  localparam int          MS_DIV_SHIFT = 38;
  localparam int          QUOT_W       = 23;

  localparam logic [16:0] UTC_OFFSET_RST     = 17'd0;
  localparam logic [31:0] SYNC_INTERVAL_RST  = 32'd900000;
  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd5000;
  localparam logic [31:0] REPLY_TIMEOUT_RST  = 32'd3000;

  typedef enum logic [1:0] {
    CFG_UTC_OFFSET     = 2'd0,
    CFG_SYNC_INTERVAL  = 2'd1,
    CFG_RETRY_INTERVAL = 2'd2,
    CFG_REPLY_TIMEOUT  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [16:0] utc_offset_seconds;
    logic [31:0] sync_interval_ms;
    logic [31:0] retry_interval_ms;
    logic [31:0] reply_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        send_accepted;
    logic        reply_present;
    logic [31:0] reply_seconds;
  } poll_t;

  typedef struct packed {
    logic send_request;
    logic sync_done;
    logic timed_out;
    logic is_synced;
  } flags_t;

  // Scheduler stage: flags, base epoch and milliseconds since base.
  typedef struct packed {
    flags_t      flags;
    logic [31:0] base_epoch;
    logic [31:0] elapsed_ms;
  } sched_t;

  // Divider stage: flags, base epoch and whole seconds since base.
  typedef struct packed {
    flags_t            flags;
    logic [31:0]       base_epoch;
    logic [QUOT_W-1:0] elapsed_s;
  } secs_t;

endpackage

/* rtl/sntp_tk_sched.sv */
// ----------------------------------------------------------------------------
// SNTP time keeper scheduler
// Holds the sync state, decides request, reply and timeout for each poll.
// ----------------------------------------------------------------------------
module sntp_tk_sched (
  input  logic                clk,
  input  logic                rst,
  input  sntp_tk_pkg::cfg_t   cfg,
  input  logic                fire,
  input  sntp_tk_pkg::poll_t  poll,
  output sntp_tk_pkg::sched_t sched
);
  import sntp_tk_pkg::*;

  logic        synced;
  logic        pending;
  logic        attempt_seen;
  logic [31:0] base_epoch;
  logic [31:0] base_ms;
  logic [31:0] last_attempt_ms;
  logic [31:0] sent_ms;

  logic        due;
  logic        issue;
  logic        start;
  logic        done;
  logic        tmo;
  logic        synced_next;
  logic        pending_next;
  logic [31:0] base_epoch_next;
  logic [31:0] reply_epoch;
  logic [31:0] offset_ext;
  logic [31:0] since_attempt;
  logic [31:0] since_base;
  logic [31:0] since_sent;

  always_comb begin
    offset_ext    = {{15{cfg.utc_offset_seconds[16]}}, cfg.utc_offset_seconds};
    since_attempt = poll.now_ms - last_attempt_ms;
    since_base    = poll.now_ms - base_ms;
    since_sent    = poll.now_ms - sent_ms;
    reply_epoch   = poll.reply_seconds - NTP_UNIX_OFFSET + offset_ext;

    if (synced) begin
      due = since_base > cfg.sync_interval_ms;
    end else begin
      due = !attempt_seen || (since_attempt > cfg.retry_interval_ms);
    end

    issue = !pending && due;
    start = issue && poll.send_accepted;
    // A request started at this poll has zero elapsed time, so only an older
    // pending request can time out.
    done  = (pending || start) && poll.reply_present;
    tmo   = pending && !poll.reply_present && (since_sent > cfg.reply_timeout_ms);

    synced_next     = synced || done;
    pending_next    = (pending || start) && !done && !tmo;
    base_epoch_next = done ? reply_epoch : base_epoch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced       <= 1'b0;
      pending      <= 1'b0;
      attempt_seen <= 1'b0;
    end else if (fire) begin
      synced  <= synced_next;
      pending <= pending_next;
      if (issue) begin
        attempt_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      base_epoch <= base_epoch_next;
      if (done) begin
        base_ms <= poll.now_ms;
      end
      if (issue) begin
        last_attempt_ms <= poll.now_ms;
      end
      if (start) begin
        sent_ms <= poll.now_ms;
      end
      sched.flags.send_request <= issue;
      sched.flags.sync_done    <= done;
      sched.flags.timed_out    <= tmo;
      sched.flags.is_synced    <= synced_next;
      sched.base_epoch         <= base_epoch_next;
      sched.elapsed_ms         <= done ? 32'd0 : since_base;
    end
  end

`include "sntp_client_time_keeper_assert.svh"

  `STK_ASSERT_IMPLIES(a_no_issue_pending, clk, rst, fire && pending, !issue, "request while pending")
  `STK_ASSERT_IMPLIES(a_done_xor_tmo, clk, rst, fire, !(done && tmo), "reply and timeout together")
  `STK_ASSERT_NEXT(a_synced_sticky, clk, rst, synced, synced, "sync state lost")

endmodule

/* rtl/sntp_tk_div.sv */
// ----------------------------------------------------------------------------
// SNTP time keeper seconds divider
// Turns elapsed milliseconds into whole seconds by a reciprocal multiply.
// ----------------------------------------------------------------------------
module sntp_tk_div (
  input  logic                clk,
  input  logic                load,
  input  sntp_tk_pkg::sched_t sched,
  output sntp_tk_pkg::secs_t  secs
);
  import sntp_tk_pkg::*;

  logic [63:0] product;

  assign product = 64'(sched.elapsed_ms) * 64'(MS_DIV_MAGIC);

  always_ff @(posedge clk) begin
    if (load) begin
      secs.flags      <= sched.flags;
      secs.base_epoch <= sched.base_epoch;
      secs.elapsed_s  <= product[MS_DIV_SHIFT +: QUOT_W];
    end
  end

endmodule

/* rtl/sntp_client_time_keeper.sv */
// ----------------------------------------------------------------------------
// SNTP client time keeper
// Poll scheduler for an SNTP client: issues requests, tracks the pending
// request, takes replies and keeps an interpolated local epoch.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  poll in  | in_valid / in_stall  | now_ms, send_accepted, reply_present,
//           |                      | reply_seconds
//  result   | out_valid / out_stall| send_request, sync_done, timed_out,
//           |                      | is_synced, local_epoch
//  config   | cfg_write            | cfg_index, cfg_data
//
//  One poll per cycle sustained while the result channel is not stalled; a
//  poll's result passes through four registers in all (input register,
//  scheduler, reciprocal multiply, epoch add) before it stands at the outputs.
//  The rate is set by the scheduler state loop.
//  Reset (rst, synchronous) empties the pipeline, clears the sync state and
//  loads the default intervals.
//  Each stage holds while the one after it is full and stalled; bubbles
//  still drain forward, so a stalled result does not stop new polls at once.
//
module sntp_client_time_keeper (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ms,
  input  logic        send_accepted,
  input  logic        reply_present,
  input  logic [31:0] reply_seconds,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_request,
  output logic        sync_done,
  output logic        timed_out,
  output logic        is_synced,
  output logic [31:0] local_epoch
);
  import sntp_tk_pkg::*;

  cfg_t   cfg;
  poll_t  poll;
  sched_t sched;
  secs_t  secs;

  logic   poll_valid;
  logic   sched_valid;
  logic   secs_valid;

  logic   out_ready;
  logic   secs_ready;
  logic   sched_ready;
  logic   poll_ready;
  logic   in_fire;
  logic   sched_fire;
  logic   secs_fire;
  logic   out_fire;

  logic [31:0] epoch_next;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.utc_offset_seconds <= UTC_OFFSET_RST;
      cfg.sync_interval_ms   <= SYNC_INTERVAL_RST;
      cfg.retry_interval_ms  <= RETRY_INTERVAL_RST;
      cfg.reply_timeout_ms   <= REPLY_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_UTC_OFFSET:     cfg.utc_offset_seconds <= cfg_data[16:0];
        CFG_SYNC_INTERVAL:  cfg.sync_interval_ms   <= cfg_data;
        CFG_RETRY_INTERVAL: cfg.retry_interval_ms  <= cfg_data;
        CFG_REPLY_TIMEOUT:  cfg.reply_timeout_ms   <= cfg_data;
      endcase
    end
  end

  // Stage ready chain: a stage can load when empty or when it empties now.
  assign out_ready   = !out_valid || !out_stall;
  assign secs_ready  = !secs_valid || out_ready;
  assign sched_ready = !sched_valid || secs_ready;
  assign poll_ready  = !poll_valid || sched_ready;

  assign in_stall   = !poll_ready;
  assign in_fire    = in_valid && poll_ready;
  assign sched_fire = poll_valid && sched_ready;
  assign secs_fire  = sched_valid && secs_ready;
  assign out_fire   = secs_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid  <= 1'b0;
      sched_valid <= 1'b0;
      secs_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (poll_ready) begin
        poll_valid <= in_valid;
      end
      if (sched_ready) begin
        sched_valid <= poll_valid;
      end
      if (secs_ready) begin
        secs_valid <= sched_valid;
      end
      if (out_ready) begin
        out_valid <= secs_valid;
      end
    end
  end

  // Input register: capture the poll.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      poll.now_ms        <= now_ms;
      poll.send_accepted <= send_accepted;
      poll.reply_present <= reply_present;
      poll.reply_seconds <= reply_seconds;
    end
  end

  // Advance the sync state once per poll as it leaves the input register.
  sntp_tk_sched u_sched (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (sched_fire),
    .poll  (poll),
    .sched (sched)
  );

  sntp_tk_div u_div (
    .clk   (clk),
    .load  (secs_fire),
    .sched (sched),
    .secs  (secs)
  );

  // Local epoch: base plus whole seconds; zero until the first reply.
  assign epoch_next = secs.flags.is_synced ?
                      secs.base_epoch + 32'(secs.elapsed_s) : 32'd0;

  always_ff @(posedge clk) begin
    if (out_fire) begin
      send_request <= secs.flags.send_request;
      sync_done    <= secs.flags.sync_done;
      timed_out    <= secs.flags.timed_out;
      is_synced    <= secs.flags.is_synced;
      local_epoch  <= epoch_next;
    end
  end

`include "sntp_client_time_keeper_assert.svh"

  `STK_ASSERT_IMPLIES(a_unsynced_zero, clk, rst, out_valid && !is_synced, local_epoch == 32'd0, "epoch nonzero while unsynced")

endmodule

/* tb/sv/tb_top.sv */
// ============================================================================
// SNTP client time keeper testbench
// Drives polls through the valid/stall input channel, predicts each poll's
// result with an independent model of the request scheduler and epoch keeper,
// and checks every result field in order, under changing register settings,
// random idling on both channels and deliberate back-pressure.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sntp_tk_pkg::*;

  // Watchdog bound, set with a wide margin over the slowest legal run of
  // every phase.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles to let pass after the last result before touching a register:
  // covers the four-stage pipeline with room to spare.
  localparam int DRAIN_CYCLES = 12;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  // One poll result as the block reports it.
  typedef struct packed {
    logic        send_request;
    logic        sync_done;
    logic        timed_out;
    logic        is_synced;
    logic [31:0] local_epoch;
  } poll_result_t;

  // A row of the directed script: a poll and, where it is obvious, the
  // result typed in by hand.
  typedef struct {
    poll_t        poll;
    bit           pinned;
    poll_result_t want;
  } script_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input is known from time zero.
  // --------------------------------------------------------------------------
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_write     = 1'b0;
  cfg_index_t  cfg_index     = CFG_UTC_OFFSET;
  logic [31:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic [31:0] now_ms        = '0;
  logic        send_accepted = 1'b0;
  logic        reply_present = 1'b0;
  logic [31:0] reply_seconds = '0;
  logic        out_stall     = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        send_request;
  logic        sync_done;
  logic        timed_out;
  logic        is_synced;
  logic [31:0] local_epoch;

  // Hand-typed result that travels with the poll on the input channel.
  logic         drv_pinned        = 1'b0;
  poll_result_t drv_pinned_result = '0;

  // --------------------------------------------------------------------------
  // Own copy of the time keeper: registers and state.
  // --------------------------------------------------------------------------
  logic [16:0] tk_utc_offset;
  logic [31:0] tk_sync_ms;
  logic [31:0] tk_retry_ms;
  logic [31:0] tk_timeout_ms;

  logic        tk_synced;
  logic [31:0] tk_base_epoch;
  logic [31:0] tk_base_ms;
  logic [31:0] tk_last_try_ms;
  logic        tk_pending;
  logic [31:0] tk_sent_ms;
  logic        tk_tried;

  // Results owed by the block, oldest first.
  poll_result_t result_store [$];

  int          polls_sent    = 0;
  int          results_taken = 0;
  int          bad_fields    = 0;
  int          cycle_count   = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  logic [31:0] poll_clock    = '0;

  // Directed script under the reset register values (retry 5000 ms, reply
  // timeout 3000 ms, resync 900000 ms, no UTC offset).
  script_row_t poll_script [19] = '{
    // first poll ever: request, but the send fails so nothing is pending
    '{'{32'd0,          1'b0, 1'b0, 32'd0},          1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    // exactly the retry interval later: not yet due
    '{'{32'd5000,       1'b1, 1'b0, 32'd0},          1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    // one past it: due, send refused, reply without a pending request ignored
    '{'{32'd5001,       1'b0, 1'b1, 32'd123},        1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    // due again, send accepted: request now pending
    '{'{32'd10002,      1'b1, 1'b0, 32'd0},          1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    // exactly the reply timeout: still waiting
    '{'{32'd13002,      1'b1, 1'b0, 32'd0},          1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    // one past it: abandon the request
    '{'{32'd13003,      1'b1, 1'b0, 32'd0},          1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 32'd0}},
    // stray reply, retry not due: ignored
    '{'{32'd13004,      1'b1, 1'b1, 32'd2208988800}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    // request and reply in the same poll: synced at the Unix epoch
    '{'{32'd15003,      1'b1, 1'b1, 32'd2208988800}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 32'd0}},
    // 999 ms later: still second zero
    '{'{32'd16002,      1'b0, 1'b0, 32'd0},          1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 32'd0}},
    '{'{32'd16003,      1'b0, 1'b0, 32'd0},          1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 32'd1}},
    // exactly the resync interval after the sync: not due
    '{'{32'd915003,     1'b1, 1'b0, 32'hFFFF_FFFF},  1'b0, '0},
    // one past it: resync request pending
    '{'{32'd915004,     1'b1, 1'b0, 32'd0},          1'b0, '0},
    // reply and timeout together: the reply wins; largest seconds value
    '{'{32'd918005,     1'b1, 1'b1, 32'hFFFF_FFFF},  1'b0, '0},
    // counter at its top, then wrapped to zero with a zero-seconds reply
    '{'{32'hFFFF_FFFF,  1'b1, 1'b0, 32'hFFFF_FFFF},  1'b0, '0},
    '{'{32'h0000_0000,  1'b0, 1'b1, 32'h0000_0000},  1'b0, '0},
    '{'{32'h7FFF_FFFF,  1'b0, 1'b0, 32'h0000_0000},  1'b0, '0},
    '{'{32'h8000_0000,  1'b1, 1'b0, 32'hAAAA_AAAA},  1'b0, '0},
    '{'{32'h8000_0BB9,  1'b1, 1'b0, 32'h5555_5555},  1'b0, '0},
    '{'{32'h8000_0BBA,  1'b1, 1'b1, 32'h5555_5555},  1'b0, '0}
  };

  sntp_client_time_keeper i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .now_ms        (now_ms),
    .send_accepted (send_accepted),
    .reply_present (reply_present),
    .reply_seconds (reply_seconds),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .send_request  (send_request),
    .sync_done     (sync_done),
    .timed_out     (timed_out),
    .is_synced     (is_synced),
    .local_epoch   (local_epoch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Time keeper model: advance the state by one poll, return its result.
  // --------------------------------------------------------------------------
  function automatic poll_result_t time_keeper_poll(poll_t p);
    poll_result_t r;
    logic         due;
    logic [31:0]  since_try;
    logic [31:0]  since_base;
    logic [31:0]  since_sent;
    r          = '0;
    since_try  = p.now_ms - tk_last_try_ms;
    since_base = p.now_ms - tk_base_ms;
    // Synced: resync period from the last sync. Unsynced: first poll, then
    // the retry period from the last attempt. All comparisons are strict.
    if (tk_synced) due = since_base > tk_sync_ms;
    else           due = !tk_tried || since_try > tk_retry_ms;

    if (!tk_pending && due) begin
      r.send_request = 1'b1;
      tk_tried       = 1'b1;
      tk_last_try_ms = p.now_ms;
      // A refused send still counts as an attempt but leaves nothing pending.
      if (p.send_accepted) begin
        tk_pending = 1'b1;
        tk_sent_ms = p.now_ms;
      end
    end

    since_sent = p.now_ms - tk_sent_ms;
    if (tk_pending) begin
      // A reply takes precedence over an expired timeout.
      if (p.reply_present) begin
        tk_base_epoch = p.reply_seconds - NTP_UNIX_OFFSET
                      + {{15{tk_utc_offset[16]}}, tk_utc_offset};
        tk_base_ms    = p.now_ms;
        tk_synced     = 1'b1;
        tk_pending    = 1'b0;
        r.sync_done   = 1'b1;
      end else if (since_sent > tk_timeout_ms) begin
        tk_pending  = 1'b0;
        r.timed_out = 1'b1;
      end
    end

    r.is_synced = tk_synced;
    if (tk_synced) begin
      since_base    = p.now_ms - tk_base_ms;
      r.local_epoch = tk_base_epoch + since_base / 32'd1000;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    bad_fields++;
    if (bad_fields <= MAX_REPORTS)
      $display("result %0d: %s expected %h got %h", results_taken, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict each accepted poll, check each
  // accepted result against the oldest prediction. Predict before checking
  // so a same-edge pair always finds its entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    poll_result_t want;
    poll_result_t got;
    if (rst) begin
      tk_utc_offset  = UTC_OFFSET_RST;
      tk_sync_ms     = SYNC_INTERVAL_RST;
      tk_retry_ms    = RETRY_INTERVAL_RST;
      tk_timeout_ms  = REPLY_TIMEOUT_RST;
      tk_synced      = 1'b0;
      tk_base_epoch  = '0;
      tk_base_ms     = '0;
      tk_last_try_ms = '0;
      tk_pending     = 1'b0;
      tk_sent_ms     = '0;
      tk_tried       = 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_UTC_OFFSET:     tk_utc_offset = cfg_data[16:0];
          CFG_SYNC_INTERVAL:  tk_sync_ms    = cfg_data;
          CFG_RETRY_INTERVAL: tk_retry_ms   = cfg_data;
          CFG_REPLY_TIMEOUT:  tk_timeout_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = time_keeper_poll({now_ms, send_accepted, reply_present, reply_seconds});
        // Hand-typed rows override the model, which still advances.
        if (drv_pinned) want = drv_pinned_result;
        result_store.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {send_request, sync_done, timed_out, is_synced, local_epoch};
        if (result_store.size() == 0) begin
          note_mismatch("unexpected result, epoch", 32'd0, got.local_epoch);
        end else begin
          want = result_store.pop_front();
          if (got.send_request !== want.send_request)
            note_mismatch("send_request", 32'(want.send_request), 32'(got.send_request));
          if (got.sync_done !== want.sync_done)
            note_mismatch("sync_done", 32'(want.sync_done), 32'(got.sync_done));
          if (got.timed_out !== want.timed_out)
            note_mismatch("timed_out", 32'(want.timed_out), 32'(got.timed_out));
          if (got.is_synced !== want.is_synced)
            note_mismatch("is_synced", 32'(want.is_synced), 32'(got.is_synced));
          if (got.local_epoch !== want.local_epoch)
            note_mismatch("local_epoch", want.local_epoch, got.local_epoch);
        end
        results_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall at rx_idle_pct, or hold off for a long stretch
  // whenever the stimulus asks for it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each returns right after a rising edge and leaves in_valid
  // as it was, so the next drive touches it only once per time step.
  // --------------------------------------------------------------------------
  task automatic drive_poll(input poll_t p, input bit pin, input poll_result_t pin_val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    now_ms            <= p.now_ms;
    send_accepted     <= p.send_accepted;
    reply_present     <= p.reply_present;
    reply_seconds     <= p.reply_seconds;
    drv_pinned        <= pin;
    drv_pinned_result <= pin_val;
    @(posedge clk);
    // Hold the item until the block takes it.
    while (in_stall) @(posedge clk);
    polls_sent++;
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_taken < polls_sent || result_store.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Polls whose time mostly creeps forward by up to 'scale' ms, with jumps of
  // one resync or retry period and the odd arbitrary jump to cross the wrap.
  // Replies come often while a request is pending, rarely otherwise.
  task automatic random_polls(input int count, input int unsigned scale);
    poll_t       p;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 4)       poll_clock = $urandom;
      else if (pick < 10) poll_clock += tk_sync_ms;
      else if (pick < 16) poll_clock += tk_retry_ms;
      else                poll_clock += $urandom_range(scale);
      p.now_ms        = poll_clock;
      p.send_accepted = ($urandom_range(99) < 80);
      if (tk_pending) p.reply_present = ($urandom_range(99) < 45);
      else            p.reply_present = ($urandom_range(99) < 8);
      if ($urandom_range(1)) p.reply_seconds = $urandom;
      else                   p.reply_seconds = NTP_UNIX_OFFSET + $urandom_range(32'h7FFF_FFFF);
      drive_poll(p, 1'b0, '0);
    end
  endtask

  // One register setting: write all four registers while idle, then random
  // polls with a full pause halfway so the sender waits on every result.
  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input logic [31:0] offset, input logic [31:0] sync_ms,
                           input logic [31:0] retry_ms, input logic [31:0] timeout_ms,
                           input int count, input int unsigned scale);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_reg(CFG_UTC_OFFSET, offset);
    write_reg(CFG_SYNC_INTERVAL, sync_ms);
    write_reg(CFG_RETRY_INTERVAL, retry_ms);
    write_reg(CFG_REPLY_TIMEOUT, timeout_ms);
    random_polls(count / 2, scale);
    wait_for_results();
    random_polls(count - count / 2, scale);
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    tx_idle_pct = 35;
    rx_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed script under the reset register values.
    foreach (poll_script[i])
      drive_poll(poll_script[i].poll, poll_script[i].pinned, poll_script[i].want);
    poll_clock = 32'h8000_0BBA;
    wait_for_results();

    // Most negative legal offset, shorter resync so it recurs.
    run_phase(35, 57, 32'(-50400), 32'd20000, 32'd5000, 32'd3000, 120, 4000);
    // Most positive legal offset, zero intervals: due on any time change.
    run_phase(57, 35, 32'd50400, 32'd0, 32'd0, 32'd0, 120, 3);
    // Long receiver hold-off while the sender keeps offering: fill the block.
    // All-ones offset write: only the low 17 bits count, giving -1.
    hold_requests++;
    run_phase(0, 0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 120, 4);
    // Offset at the 17-bit sign boundary, largest intervals: nothing is ever
    // due again and a pending request never times out.
    run_phase(0, 0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              120, 1000);
    // Ordinary mid-range setting.
    run_phase(0, 0, 32'd12345, 32'd7000, 32'd1500, 32'd800, 120, 2000);

    // Anything still owed counts against the run.
    if (result_store.size() != 0)
      note_mismatch("results never delivered", 32'd0, 32'(result_store.size()));

    if (bad_fields == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
